// File: hw/rtl/stt_pkg.sv
package stt_pkg;

   // token kinds
   localparam logic [3:0] KIND_ID      = 4'd0;
   localparam logic [3:0] KIND_INT     = 4'd1;
   localparam logic [3:0] KIND_STRING  = 4'd2;
   localparam logic [3:0] KIND_ARROW   = 4'd3;
   localparam logic [3:0] KIND_LPAREN  = 4'd4;
   localparam logic [3:0] KIND_RPAREN  = 4'd5;
   localparam logic [3:0] KIND_COMMA   = 4'd6;
   localparam logic [3:0] KIND_EQUAL   = 4'd7;
   localparam logic [3:0] KIND_LBRACK  = 4'd8;
   localparam logic [3:0] KIND_RBRACK  = 4'd9;
   localparam logic [3:0] KIND_LBRACE  = 4'd10;
   localparam logic [3:0] KIND_RBRACE  = 4'd11;
   localparam logic [3:0] KIND_SEMI    = 4'd12;
   localparam logic [3:0] KIND_UNKNOWN = 4'd13;
   localparam logic [3:0] KIND_END     = 4'd14;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DIG_LO = 8'h30;
   localparam logic [7:0] CH_DIG_HI = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UC_LO  = 8'h41;
   localparam logic [7:0] CH_UC_HI  = 8'h5A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LC_LO  = 8'h61;
   localparam logic [7:0] CH_LC_HI  = 8'h7A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic        unterm;
      logic        last;
   } rec_type;

   // records produced by one accepted byte
   typedef struct packed {
      logic [1:0] count;
      rec_type    first;
      rec_type    second;
   } push_type;

   function automatic logic is_letter(input logic [7:0] b);
      return b inside {[CH_LC_LO:CH_LC_HI], [CH_UC_LO:CH_UC_HI], CH_UNDER};
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[CH_DIG_LO:CH_DIG_HI]};
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
   endfunction

   // unknown for anything that is not a single punctuation character
   function automatic logic [3:0] punct_kind(input logic [7:0] b);
      logic [3:0] k;
      case (b)
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_COMMA:  k = KIND_COMMA;
         CH_EQUAL:  k = KIND_EQUAL;
         CH_LBRACK: k = KIND_LBRACK;
         CH_RBRACK: k = KIND_RBRACK;
         CH_LBRACE: k = KIND_LBRACE;
         CH_RBRACE: k = KIND_RBRACE;
         CH_SEMI:   k = KIND_SEMI;
         default:   k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

// File: hw/rtl/stt_scan.sv
module stt_scan #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16,
   parameter int LINE_BITS     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        text_byte,
   output stt_pkg::push_type push
);
   import stt_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_MINUS,
      MODE_DONE
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [POSITION_BITS-1:0] open_start_ff, open_start_in;
   logic [LENGTH_BITS-1:0]   open_len_ff, open_len_in;
   logic [LINE_BITS-1:0]     open_line_ff, open_line_in;

   // fresh-byte path
   mode_type                 f_mode;
   logic [POSITION_BITS-1:0] f_pos;
   logic [LINE_BITS-1:0]     f_line;
   logic [POSITION_BITS-1:0] f_start;
   logic [LENGTH_BITS-1:0]   f_len;
   logic                     f_open;
   logic                     f_emit;
   rec_type                  f_rec;

   // record from the token the byte closes
   logic    c_emit;
   logic    use_fresh;
   rec_type c_rec;

   logic [POSITION_BITS-1:0] pos_inc;
   logic [LENGTH_BITS-1:0]   len_inc;

   function automatic rec_type make_rec(input logic [3:0] kind,
                                        input logic [POSITION_BITS-1:0] start,
                                        input logic [LENGTH_BITS-1:0] len,
                                        input logic [LINE_BITS-1:0] line,
                                        input logic unterm);
      rec_type r;
      logic [63:0] s_w, l_w, n_w;
      s_w = 64'(start);
      l_w = 64'(len);
      n_w = 64'(line);
      r.kind   = kind;
      r.start  = s_w[31:0];
      r.length = l_w[15:0];
      r.line   = n_w[15:0];
      r.unterm = unterm;
      r.last   = 1'b0;
      return r;
   endfunction

   assign pos_inc = pos_ff + POSITION_BITS'(1);
   assign len_inc = (&open_len_ff) ? open_len_ff : open_len_ff + LENGTH_BITS'(1);

   always_comb begin
      f_mode  = MODE_IDLE;
      f_pos   = pos_inc;
      f_line  = line_ff;
      f_start = pos_ff;
      f_len   = LENGTH_BITS'(1);
      f_open  = 1'b0;
      f_emit  = 1'b0;
      f_rec   = make_rec(KIND_END, pos_ff, '0, line_ff, 1'b0);
      if (text_byte == CH_NUL) begin
         f_mode = MODE_DONE;
         f_pos  = pos_ff;
         f_emit = 1'b1;
      end else if (is_space(text_byte)) begin
         if (text_byte == CH_LF && !(&line_ff)) begin
            f_line = line_ff + LINE_BITS'(1);
         end
      end else if (is_letter(text_byte)) begin
         f_mode = MODE_IDENT;
         f_open = 1'b1;
      end else if (is_digit(text_byte)) begin
         f_mode = MODE_NUMBER;
         f_open = 1'b1;
      end else if (text_byte == CH_QUOTE) begin
         f_mode  = MODE_STRING;
         f_open  = 1'b1;
         f_start = pos_inc;
         f_len   = '0;
      end else if (text_byte == CH_MINUS) begin
         f_mode = MODE_MINUS;
         f_open = 1'b1;
      end else begin
         f_emit = 1'b1;
         f_rec  = make_rec(punct_kind(text_byte), pos_ff, LENGTH_BITS'(1), line_ff, 1'b0);
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      line_in       = line_ff;
      open_start_in = open_start_ff;
      open_len_in   = open_len_ff;
      open_line_in  = open_line_ff;
      c_emit        = 1'b0;
      use_fresh     = 1'b0;
      c_rec         = make_rec(KIND_ID, open_start_ff, open_len_ff, open_line_ff, 1'b0);
      case (mode_ff)
         MODE_IDENT, MODE_NUMBER: begin
            if (is_digit(text_byte) || (mode_ff == MODE_IDENT && is_letter(text_byte))) begin
               open_len_in = len_inc;
               pos_in      = pos_inc;
            end else begin
               c_emit    = 1'b1;
               use_fresh = 1'b1;
               if (mode_ff == MODE_NUMBER) begin
                  c_rec.kind = KIND_INT;
               end
            end
         end
         MODE_STRING: begin
            c_rec.kind = KIND_STRING;
            if (text_byte == CH_QUOTE) begin
               c_emit  = 1'b1;
               mode_in = MODE_IDLE;
               pos_in  = pos_inc;
            end else if (text_byte == CH_NUL) begin
               c_emit       = 1'b1;
               c_rec.unterm = 1'b1;
               use_fresh    = 1'b1;
            end else begin
               open_len_in = len_inc;
               pos_in      = pos_inc;
            end
         end
         MODE_MINUS: begin
            c_emit = 1'b1;
            if (text_byte == CH_GT) begin
               c_rec   = make_rec(KIND_ARROW, open_start_ff, LENGTH_BITS'(2), open_line_ff,
                                  1'b0);
               mode_in = MODE_IDLE;
               pos_in  = pos_inc;
            end else begin
               c_rec     = make_rec(KIND_UNKNOWN, open_start_ff, LENGTH_BITS'(1),
                                    open_line_ff, 1'b0);
               use_fresh = 1'b1;
            end
         end
         MODE_DONE: begin
            c_emit = 1'b1;
            c_rec  = make_rec(KIND_END, pos_ff, '0, line_ff, 1'b0);
         end
         default: begin
            use_fresh = 1'b1;
         end
      endcase
      if (use_fresh) begin
         mode_in = f_mode;
         pos_in  = f_pos;
         line_in = f_line;
         if (f_open) begin
            open_start_in = f_start;
            open_len_in   = f_len;
            open_line_in  = line_ff;
         end
      end
   end

   always_comb begin
      push        = '0;
      push.first  = c_emit ? c_rec : f_rec;
      push.second = f_rec;
      if (c_emit && use_fresh && f_emit) begin
         push.count       = 2'd2;
         push.second.last = 1'b1;
      end else if (c_emit || (use_fresh && f_emit)) begin
         push.count      = 2'd1;
         push.first.last = 1'b1;
      end
      if (!advance) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         pos_ff        <= '0;
         line_ff       <= LINE_BITS'(1);
         open_start_ff <= '0;
         open_len_ff   <= '0;
         open_line_ff  <= LINE_BITS'(1);
      end else if (advance) begin
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         line_ff       <= line_in;
         open_start_ff <= open_start_in;
         open_len_ff   <= open_len_in;
         open_line_ff  <= open_line_in;
      end
   end

endmodule

// File: hw/rtl/stt_rsp_queue.sv
module stt_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  stt_pkg::push_type push,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output stt_pkg::rec_type  out_rec
);
   import stt_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   rec_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != '0;
   assign out_rec   = entry_ff[rd_ptr_ff];
   // keep space for the two records one byte can produce
   assign room      = count_ff <= (PTR_BITS + 1)'(QUEUE_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + (PTR_BITS + 1)'(push.count) - (PTR_BITS + 1)'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/source_text_tokenizer.sv
// Streaming tokenizer: one source byte per request, a zero byte ends the text. Each byte
// updates the scanner state in the cycle it is accepted and yields zero, one or two token
// records (kind, start offset, length, start line), which go into a four-entry result
// queue; tlast marks the last record a byte caused and tuser flags a string closed by end
// of text. The block takes one byte per clock as long as the queue has room for two
// records, so the sustained rate is one byte per cycle, limited only by how fast the
// result side drains records. After the end token every further byte yields another end
// token until reset.
module source_text_tokenizer #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16,
   parameter int LINE_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] token_kind, [35:4] token_start,
                                    // [51:36] token_length, [67:52] token_line
   output logic        rsp_tuser,   // [0] unterminated
   output logic        rsp_tlast    // last_of_run
);
   import stt_pkg::*;

   logic     room;
   logic     advance;
   push_type push;
   rec_type  rec;

   assign req_tready = room;
   assign advance    = req_tvalid && room;

   stt_scan #(
      .POSITION_BITS(POSITION_BITS),
      .LENGTH_BITS  (LENGTH_BITS),
      .LINE_BITS    (LINE_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .text_byte(req_tdata),
      .push     (push)
   );

   stt_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_rec  (rec)
   );

   assign rsp_tdata = {4'b0000, rec.line, rec.length, rec.start, rec.kind};
   assign rsp_tuser = rec.unterm;
   assign rsp_tlast = rec.last;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import stt_pkg::*;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_MINUS, SCAN_DONE
   } scan_mode_type;

   localparam logic [7:0] SYMBOLS [9] = '{CH_LPAREN, CH_RPAREN, CH_COMMA, CH_EQUAL,
                                          CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
                                          CH_SEMI};
   localparam int TEXT_ITEMS = 1340;

   // Tracks the scanner state and holds the token records still owed by the block.
   class token_book_type;
      scan_mode_type mode;
      logic [31:0]   pos;
      logic [15:0]   cur_line;
      logic [31:0]   open_start;
      logic [15:0]   open_len;
      logic [15:0]   open_line;
      rec_type       pending_tokens[$];
      rec_type       batch[$];
      int            errors;

      function new();
         mode = SCAN_IDLE;
         pos = '0;
         cur_line = 16'd1;
         open_start = '0;
         open_len = '0;
         open_line = 16'd1;
         errors = 0;
      endfunction

      function bit alpha(logic [7:0] c);
         return (c >= CH_LC_LO && c <= CH_LC_HI) || (c >= CH_UC_LO && c <= CH_UC_HI) ||
                c == CH_UNDER;
      endfunction

      function bit numeral(logic [7:0] c);
         return c >= CH_DIG_LO && c <= CH_DIG_HI;
      endfunction

      function logic [3:0] symbol_kind(logic [7:0] c);
         case (c)
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            CH_COMMA:  return KIND_COMMA;
            CH_EQUAL:  return KIND_EQUAL;
            CH_LBRACK: return KIND_LBRACK;
            CH_RBRACK: return KIND_RBRACK;
            CH_LBRACE: return KIND_LBRACE;
            CH_RBRACE: return KIND_RBRACE;
            CH_SEMI:   return KIND_SEMI;
            default:   return KIND_UNKNOWN;
         endcase
      endfunction

      function void add(logic [3:0] kind, logic [31:0] start, logic [15:0] len,
                        logic [15:0] ln, logic unterm);
         rec_type r;
         r.kind = kind;
         r.start = start;
         r.length = len;
         r.line = ln;
         r.unterm = unterm;
         r.last = 1'b0;
         batch.push_back(r);
      endfunction

      function void begin_token(scan_mode_type m, logic [31:0] start, logic [15:0] len);
         mode = m;
         open_start = start;
         open_len = len;
         open_line = cur_line;
      endfunction

      // byte seen with no token open
      function void scan_fresh(logic [7:0] c);
         logic [31:0] p;
         p = pos;
         if (c == CH_NUL) begin
            mode = SCAN_DONE;
            add(KIND_END, p, 16'd0, cur_line, 1'b0);
            return;
         end
         pos = p + 32'd1;
         if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
            if (c == CH_LF && cur_line != 16'hFFFF) cur_line = cur_line + 16'd1;
         end else if (alpha(c)) begin
            begin_token(SCAN_IDENT, p, 16'd1);
         end else if (numeral(c)) begin
            begin_token(SCAN_NUMBER, p, 16'd1);
         end else if (c == CH_QUOTE) begin
            begin_token(SCAN_STRING, p + 32'd1, 16'd0);
         end else if (c == CH_MINUS) begin
            begin_token(SCAN_MINUS, p, 16'd1);
         end else begin
            add(symbol_kind(c), p, 16'd1, cur_line, 1'b0);
         end
      endfunction

      function void grow();
         if (open_len != 16'hFFFF) open_len = open_len + 16'd1;
         pos = pos + 32'd1;
      endfunction

      function void note_byte(logic [7:0] c);
         bit more;
         batch.delete();
         case (mode)
            SCAN_IDENT, SCAN_NUMBER: begin
               more = (mode == SCAN_IDENT) ? (alpha(c) || numeral(c)) : numeral(c);
               if (more) begin
                  grow();
               end else begin
                  add(mode == SCAN_IDENT ? KIND_ID : KIND_INT, open_start, open_len,
                      open_line, 1'b0);
                  mode = SCAN_IDLE;
                  scan_fresh(c);
               end
            end
            SCAN_STRING: begin
               if (c == CH_QUOTE) begin
                  add(KIND_STRING, open_start, open_len, open_line, 1'b0);
                  mode = SCAN_IDLE;
                  pos = pos + 32'd1;
               end else if (c == CH_NUL) begin
                  add(KIND_STRING, open_start, open_len, open_line, 1'b1);
                  mode = SCAN_IDLE;
                  scan_fresh(c);
               end else begin
                  grow();
               end
            end
            SCAN_MINUS: begin
               mode = SCAN_IDLE;
               if (c == CH_GT) begin
                  add(KIND_ARROW, open_start, 16'd2, open_line, 1'b0);
                  pos = pos + 32'd1;
               end else begin
                  add(KIND_UNKNOWN, open_start, 16'd1, open_line, 1'b0);
                  scan_fresh(c);
               end
            end
            SCAN_DONE: add(KIND_END, pos, 16'd0, cur_line, 1'b0);
            default: scan_fresh(c);
         endcase
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) pending_tokens.push_back(batch[i]);
      endfunction

      function void check_field(string what, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         end
      endfunction

      function void check_record(logic [71:0] data, logic unterm, logic last);
         rec_type want;
         if (pending_tokens.size() == 0) begin
            errors++;
            $display("%0t: unexpected token record, expected none, actual kind %0d start %0d",
                     $time, data[3:0], data[35:4]);
            return;
         end
         want = pending_tokens.pop_front();
         check_field("token_kind", 64'(want.kind), 64'(data[3:0]));
         check_field("token_start", 64'(want.start), 64'(data[35:4]));
         check_field("token_length", 64'(want.length), 64'(data[51:36]));
         check_field("token_line", 64'(want.line), 64'(data[67:52]));
         check_field("unterminated", 64'(want.unterm), 64'(unterm));
         check_field("last_of_run", 64'(want.last), 64'(last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   token_book_type book = new();
   logic [7:0]     text_q[$];

   source_text_tokenizer dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) book.note_byte(req_tdata);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_record(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   function automatic void push_text(string s);
      foreach (s[i]) text_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] any_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return CH_LC_LO + 8'(r);
      if (r < 52) return CH_UC_LO + 8'(r - 26);
      return CH_UNDER;
   endfunction

   function automatic logic [7:0] any_digit();
      return CH_DIG_LO + 8'($urandom_range(0, 9));
   endfunction

   // tokens with random content (some strings left unclosed), some noise in between
   function automatic void add_random_token();
      int pick;
      int n;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         text_q.push_back(any_letter());
         n = $urandom_range(0, 9);
         repeat (n) text_q.push_back($urandom_range(0, 2) == 0 ? any_digit() : any_letter());
      end else if (pick < 40) begin
         n = $urandom_range(1, 6);
         repeat (n) text_q.push_back(any_digit());
      end else if (pick < 50) begin
         text_q.push_back(CH_QUOTE);
         n = $urandom_range(0, 12);
         repeat (n) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
            text_q.push_back(c);
         end
         if ($urandom_range(0, 9) != 0) text_q.push_back(CH_QUOTE);
      end else if (pick < 58) begin
         text_q.push_back(CH_MINUS);
         text_q.push_back(CH_GT);
      end else if (pick < 63) begin
         text_q.push_back(CH_MINUS);
      end else if (pick < 78) begin
         text_q.push_back(SYMBOLS[4'($urandom_range(0, 8))]);
      end else if (pick < 90) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            case ($urandom_range(0, 3))
               0: text_q.push_back(CH_SPACE);
               1: text_q.push_back(CH_TAB);
               2: text_q.push_back(CH_CR);
               default: text_q.push_back(CH_LF);
            endcase
         end
      end else begin
         text_q.push_back(8'($urandom_range(1, 255)));
      end
   endfunction

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // hold the byte until the block takes it
   task automatic send_byte(logic [7:0] c, bit calm);
      int gap;
      gap = pick_gap(calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      bit calm;
      calm = 1'b0;
      push_text("x(4a)\t->-,\n\"q\n\"[]{}=;");
      text_q.push_back(8'hFF);
      push_text("-5\r");
      while (text_q.size() < TEXT_ITEMS) add_random_token();
      // string left open at end of text, then bytes after the end
      push_text("\"a\n");
      text_q.push_back(CH_NUL);
      text_q.push_back(CH_NUL);
      text_q.push_back(CH_LC_LO);
      text_q.push_back(8'hFF);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (text_q[i]) begin
         if ($urandom_range(0, 99) == 0) calm = !calm;
         send_byte(text_q[i], calm);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (book.errors == 0 && book.pending_tokens.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // result side: random stalls, calm stretches and one long hold-off
   initial begin
      int cycle;
      int hold;
      int r;
      bit calm;
      cycle = 0;
      hold = 0;
      calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cycle++;
         if ($urandom_range(0, 149) == 0) calm = !calm;
         if (cycle == 800) hold = 400;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
               rsp_tready <= 1'b1;
            end else begin
               hold = (r < 97) ? $urandom_range(0, 2) : $urandom_range(15, 50);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_scan.sv
hw/rtl/stt_rsp_queue.sv
hw/rtl/source_text_tokenizer.sv
verif/testbench.sv
